### hdl/ckb_pkg.sv
// Shared types and constants for the color-keyed sprite blit unit.
package ckb_pkg;

	localparam int unsigned CfgIndexBits = 3;

	localparam logic [CfgIndexBits-1:0] REG_COLOR_KEY     = 3'd0;
	localparam logic [CfgIndexBits-1:0] REG_DEST_WIDTH    = 3'd1;
	localparam logic [CfgIndexBits-1:0] REG_DEST_HEIGHT   = 3'd2;
	localparam logic [CfgIndexBits-1:0] REG_SPRITE_WIDTH  = 3'd3;
	localparam logic [CfgIndexBits-1:0] REG_SPRITE_HEIGHT = 3'd4;
	localparam logic [CfgIndexBits-1:0] REG_CENTER_X      = 3'd5;
	localparam logic [CfgIndexBits-1:0] REG_CENTER_Y      = 3'd6;
	localparam logic [CfgIndexBits-1:0] REG_SPRITE_MODE   = 3'd7;

	localparam logic [1:0] MODE_CHAR   = 2'd0;
	localparam logic [1:0] MODE_SHADOW = 2'd1;
	localparam logic [1:0] MODE_GAUGE  = 2'd2;

	localparam logic [23:0] RESET_COLOR_KEY   = 24'hFF_FFFF;
	localparam logic [12:0] RESET_DEST_WIDTH  = 13'd640;
	localparam logic [12:0] RESET_DEST_HEIGHT = 13'd480;
	localparam logic [12:0] RESET_SPRITE_DIM  = 13'd1;

	localparam logic [6:0] PERCENT_SCALE = 7'd100;

	typedef struct packed {
		logic [23:0] color_key;
		logic [12:0] dest_width;
		logic [12:0] dest_height;
		logic [12:0] sprite_width;
		logic [12:0] sprite_height;
		logic [11:0] center_x;
		logic [11:0] center_y;
		logic [1:0]  sprite_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] draw_x;
		logic signed [15:0] draw_y;
		logic [11:0]        src_col;
		logic [11:0]        src_row;
		logic [31:0]        src_pixel;
		logic [31:0]        dest_pixel;
		logic               tint_player;
		logic [6:0]         draw_percent;
	} pix_in_t;

endpackage

### hdl/ckb_pix_in_if.sv
// Input pixel channel: sprite pixel, draw point and back-buffer pixel.
interface ckb_pix_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] draw_x;
	logic signed [15:0] draw_y;
	logic [11:0]        src_col;
	logic [11:0]        src_row;
	logic [31:0]        src_pixel;
	logic [31:0]        dest_pixel;
	logic               tint_player;
	logic [6:0]         draw_percent;

	modport source (
		output valid, draw_x, draw_y, src_col, src_row, src_pixel, dest_pixel,
			tint_player, draw_percent,
		input  ready
	);
	modport sink (
		input  valid, draw_x, draw_y, src_col, src_row, src_pixel, dest_pixel,
			tint_player, draw_percent,
		output ready
	);
endinterface

### hdl/ckb_pix_out_if.sv
// Output channel: write decision, destination position and written RGB.
interface ckb_pix_out_if #(
	parameter int unsigned COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  write_enable;
	logic [COORD_BITS-1:0] dest_col;
	logic [COORD_BITS-1:0] dest_row;
	logic [23:0]           out_pixel;

	modport source (
		output valid, write_enable, dest_col, dest_row, out_pixel,
		input  ready
	);
	modport sink (
		input  valid, write_enable, dest_col, dest_row, out_pixel,
		output ready
	);
endinterface

### hdl/ckb_cfg_if.sv
// Configuration write channel: register index and write data.
interface ckb_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ckb_pkg::CfgIndexBits-1:0] index;
	logic [23:0]                      data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

### hdl/ckb_cfg.sv
// Configuration register file for the blit unit.
module ckb_cfg (
	input  logic           clk,
	input  logic           arst_n,
	ckb_cfg_if.sink        cfg,
	output ckb_pkg::cfg_t  regs
);
	ckb_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.color_key     <= ckb_pkg::RESET_COLOR_KEY;
			regs_q.dest_width    <= ckb_pkg::RESET_DEST_WIDTH;
			regs_q.dest_height   <= ckb_pkg::RESET_DEST_HEIGHT;
			regs_q.sprite_width  <= ckb_pkg::RESET_SPRITE_DIM;
			regs_q.sprite_height <= ckb_pkg::RESET_SPRITE_DIM;
			regs_q.center_x      <= '0;
			regs_q.center_y      <= '0;
			regs_q.sprite_mode   <= ckb_pkg::MODE_CHAR;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ckb_pkg::REG_COLOR_KEY:     regs_q.color_key     <= cfg.data;
				ckb_pkg::REG_DEST_WIDTH:    regs_q.dest_width    <= cfg.data[12:0];
				ckb_pkg::REG_DEST_HEIGHT:   regs_q.dest_height   <= cfg.data[12:0];
				ckb_pkg::REG_SPRITE_WIDTH:  regs_q.sprite_width  <= cfg.data[12:0];
				ckb_pkg::REG_SPRITE_HEIGHT: regs_q.sprite_height <= cfg.data[12:0];
				ckb_pkg::REG_CENTER_X:      regs_q.center_x      <= cfg.data[11:0];
				ckb_pkg::REG_CENTER_Y:      regs_q.center_y      <= cfg.data[11:0];
				ckb_pkg::REG_SPRITE_MODE:   regs_q.sprite_mode   <= cfg.data[1:0];
				default: ;
			endcase
		end
	end
endmodule

### hdl/ckb_calc.sv
// Placement, clipping, color key test and pixel shading for one sprite pixel.
module ckb_calc #(
	parameter int unsigned COORD_BITS = 12
) (
	input  ckb_pkg::pix_in_t       pix,
	input  ckb_pkg::cfg_t          regs,
	output logic                   write_enable,
	output logic [COORD_BITS-1:0]  dest_col,
	output logic [COORD_BITS-1:0]  dest_row,
	output logic [23:0]            out_pixel
);
	localparam logic [16:0] CoordLimit = 17'(1) << COORD_BITS;

	logic signed [17:0] sx, sy, dcol, drow, lclip, rclip_raw, rclip, k;
	logic signed [19:0] vis;
	logic [18:0]        k_scaled;
	logic [19:0]        vis_scaled;
	logic               inside_sprite, col_ok, row_ok, share_ok, key_ok, ok;
	logic [7:0]         r, g, b;

	always_comb begin
		sx   = {{2{pix.draw_x[15]}}, pix.draw_x} - $signed({6'b0, regs.center_x});
		sy   = {{2{pix.draw_y[15]}}, pix.draw_y} - $signed({6'b0, regs.center_y});
		dcol = sx + $signed({6'b0, pix.src_col});
		drow = sy + $signed({6'b0, pix.src_row});

		// clip amounts on each side add up
		lclip     = sx[17] ? -sx : 18'sd0;
		rclip_raw = sx + $signed({5'b0, regs.sprite_width}) - $signed({5'b0, regs.dest_width});
		rclip     = rclip_raw[17] ? 18'sd0 : rclip_raw;
		vis       = $signed({7'b0, regs.sprite_width}) - {{2{lclip[17]}}, lclip}
			- {{2{rclip[17]}}, rclip};
		k         = $signed({6'b0, pix.src_col}) - lclip;

		k_scaled   = 19'(k[11:0] * ckb_pkg::PERCENT_SCALE);
		vis_scaled = 20'(vis[12:0] * pix.draw_percent);

		inside_sprite = ({1'b0, pix.src_col} < regs.sprite_width)
			&& ({1'b0, pix.src_row} < regs.sprite_height);
		col_ok = !dcol[17] && (dcol[16:0] < {4'b0, regs.dest_width})
			&& (dcol[16:0] < CoordLimit);
		row_ok = !drow[17] && (drow[16:0] < {4'b0, regs.dest_height})
			&& (drow[16:0] < CoordLimit);
		share_ok = !vis[19] && (vis != 20'sd0) && !k[17]
			&& ({1'b0, k_scaled} < vis_scaled);
		key_ok = pix.src_pixel[23:0] != regs.color_key;
		ok     = inside_sprite && col_ok && row_ok && share_ok && key_ok;

		r = pix.src_pixel[23:16];
		g = pix.src_pixel[15:8];
		b = pix.src_pixel[7:0];
		if (regs.sprite_mode == ckb_pkg::MODE_SHADOW) begin
			r = r + {1'b0, pix.dest_pixel[23:17]};
			g = g + {1'b0, pix.dest_pixel[15:9]};
			b = b + {1'b0, pix.dest_pixel[7:1]};
		end else if (regs.sprite_mode != ckb_pkg::MODE_GAUGE && pix.tint_player) begin
			g = {1'b0, g[7:1]};
			b = {1'b0, b[7:1]};
		end

		write_enable = ok;
		dest_col     = ok ? dcol[COORD_BITS-1:0] : '0;
		dest_row     = ok ? drow[COORD_BITS-1:0] : '0;
		out_pixel    = ok ? {r, g, b} : 24'h0;
	end
endmodule

### hdl/color_key_sprite_pixel_blit_unit.sv
// Top level of the color-keyed sprite blit unit: input stage, compute and result stage.
//
//   channel   dir   payload
//   pix_in    in    draw_x, draw_y, src_col, src_row, src_pixel, dest_pixel,
//                   tint_player, draw_percent
//   pix_out   out   write_enable, dest_col, dest_row, out_pixel
//   cfg       in    index, data (register write, always ready)
//
// One pixel per clock sustained while the sink keeps pix_out ready. A transaction accepted
// into the input register has its result computed by ckb_calc and loaded into the result
// register, where it waits until the sink takes it.
// The two stages hold up to two transactions: while a result waits, pix_in stays
// ready only as long as the input stage is empty.
// arst_n clears the stage valid flags and loads the register reset values.
module color_key_sprite_pixel_blit_unit #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	ckb_pix_in_if.sink       pix_in,
	ckb_pix_out_if.source    pix_out,
	ckb_cfg_if.sink          cfg
);
	ckb_pkg::cfg_t         regs;
	ckb_pkg::pix_in_t      pix_s1;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  advance_s2;
	logic                  we_c;
	logic [COORD_BITS-1:0] col_c, row_c;
	logic [23:0]           rgb_c;
	logic                  we_s2;
	logic [COORD_BITS-1:0] col_s2, row_s2;
	logic [23:0]           rgb_s2;

	ckb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ckb_calc #(.COORD_BITS(COORD_BITS)) u_calc (
		.pix          (pix_s1),
		.regs         (regs),
		.write_enable (we_c),
		.dest_col     (col_c),
		.dest_row     (row_c),
		.out_pixel    (rgb_c)
	);

	assign advance_s2   = !valid_s2 || pix_out.ready;
	assign pix_in.ready = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pix_in.ready)
				valid_s1 <= pix_in.valid;
			if (advance_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.ready && pix_in.valid) begin
			pix_s1.draw_x       <= pix_in.draw_x;
			pix_s1.draw_y       <= pix_in.draw_y;
			pix_s1.src_col      <= pix_in.src_col;
			pix_s1.src_row      <= pix_in.src_row;
			pix_s1.src_pixel    <= pix_in.src_pixel;
			pix_s1.dest_pixel   <= pix_in.dest_pixel;
			pix_s1.tint_player  <= pix_in.tint_player;
			pix_s1.draw_percent <= pix_in.draw_percent;
		end
		// hold the result while the sink stalls
		if (advance_s2 && valid_s1) begin
			we_s2  <= we_c;
			col_s2 <= col_c;
			row_s2 <= row_c;
			rgb_s2 <= rgb_c;
		end
	end

	assign pix_out.valid        = valid_s2;
	assign pix_out.write_enable = we_s2;
	assign pix_out.dest_col     = col_s2;
	assign pix_out.dest_row     = row_s2;
	assign pix_out.out_pixel    = rgb_s2;
endmodule

### verif/color_key_sprite_pixel_blit_unit_test.sv
// Testbench for the color-keyed sprite blit unit: directed and random pixels vs. a predictor.
`timescale 1ns / 100ps

module color_key_sprite_pixel_blit_unit_test;

	localparam int CoordBits = 12;
	localparam longint CoordLimit = longint'(1) << CoordBits;
	localparam int CycleLimit = 400000;
	localparam int ReportLimit = 10;
	localparam int DrainCycles = 4;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic        we;
		logic [11:0] col;
		logic [11:0] row;
		logic [23:0] rgb;
	} blit_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ckb_pix_in_if pix_in ();
	ckb_pix_out_if #(.COORD_BITS(CoordBits)) pix_out ();
	ckb_cfg_if cfg ();

	color_key_sprite_pixel_blit_unit #(.COORD_BITS(CoordBits)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	ckb_pkg::cfg_t blit_regs;
	blit_result_t  pending_writes[$];
	blit_result_t  want;
	int            mismatches = 0;
	int            cycle_count = 0;
	int            stall_left = 0;
	bit            steady = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_writes.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic ckb_pkg::cfg_t make_cfg(input logic [23:0] key, input int dw,
			input int dh, input int sw, input int sh, input int cx, input int cy,
			input logic [1:0] mode);
		ckb_pkg::cfg_t c;
		c.color_key     = key;
		c.dest_width    = 13'(dw);
		c.dest_height   = 13'(dh);
		c.sprite_width  = 13'(sw);
		c.sprite_height = 13'(sh);
		c.center_x      = 12'(cx);
		c.center_y      = 12'(cy);
		c.sprite_mode   = mode;
		return c;
	endfunction

	function automatic ckb_pkg::pix_in_t make_pixel(input int x, input int y, input int col,
			input int row, input logic [31:0] spx, input logic [31:0] dpx, input bit tint,
			input int pct);
		ckb_pkg::pix_in_t p;
		p.draw_x       = 16'(x);
		p.draw_y       = 16'(y);
		p.src_col      = 12'(col);
		p.src_row      = 12'(row);
		p.src_pixel    = spx;
		p.dest_pixel   = dpx;
		p.tint_player  = tint;
		p.draw_percent = 7'(pct);
		return p;
	endfunction

	// Clip, key test and shading of one sprite pixel under the current registers.
	function automatic blit_result_t predict_blit(input ckb_pkg::pix_in_t p);
		blit_result_t res;
		longint sx, sy, dcol, drow, lclip, rclip, vis, k, sw, sh, dw, dh;
		logic [23:0] rgb;
		logic [7:0] r, g, b;
		bit hit;
		sw = longint'(blit_regs.sprite_width);
		sh = longint'(blit_regs.sprite_height);
		dw = longint'(blit_regs.dest_width);
		dh = longint'(blit_regs.dest_height);
		sx = longint'($signed(p.draw_x)) - longint'(blit_regs.center_x);
		sy = longint'($signed(p.draw_y)) - longint'(blit_regs.center_y);
		dcol = sx + longint'(p.src_col);
		drow = sy + longint'(p.src_row);
		lclip = (-sx > 0) ? -sx : 0;
		rclip = (sx + sw - dw > 0) ? sx + sw - dw : 0;
		vis = sw - lclip - rclip;
		k = longint'(p.src_col) - lclip;
		rgb = p.src_pixel[23:0];
		hit = 1'b1;
		if (longint'(p.src_col) >= sw || longint'(p.src_row) >= sh)
			hit = 1'b0;
		if (dcol < 0 || dcol >= dw || dcol >= CoordLimit)
			hit = 1'b0;
		if (drow < 0 || drow >= dh || drow >= CoordLimit)
			hit = 1'b0;
		if (vis <= 0 || k < 0 || k * 100 >= vis * longint'(p.draw_percent))
			hit = 1'b0;
		if (rgb == blit_regs.color_key)
			hit = 1'b0;
		res.we = 1'b0;
		res.col = '0;
		res.row = '0;
		res.rgb = '0;
		if (hit) begin
			r = rgb[23:16];
			g = rgb[15:8];
			b = rgb[7:0];
			if (blit_regs.sprite_mode == ckb_pkg::MODE_SHADOW) begin
				r = r + (p.dest_pixel[23:16] >> 1);
				g = g + (p.dest_pixel[15:8] >> 1);
				b = b + (p.dest_pixel[7:0] >> 1);
			end else if (blit_regs.sprite_mode != ckb_pkg::MODE_GAUGE && p.tint_player) begin
				g = g >> 1;
				b = b >> 1;
			end
			res.we = 1'b1;
			res.col = dcol[11:0];
			res.row = drow[11:0];
			res.rgb = {r, g, b};
		end
		return res;
	endfunction

	function automatic ckb_pkg::cfg_t random_cfg();
		int dw, dh, sw, sh, cx, cy;
		logic [23:0] key;
		case ($urandom_range(0, 9))
			0: dw = 1;
			1: dw = 4096;
			2, 3: dw = $urandom_range(1, 4096);
			default: dw = $urandom_range(1, 256);
		endcase
		case ($urandom_range(0, 9))
			0: dh = 1;
			1: dh = 4096;
			2, 3: dh = $urandom_range(1, 4096);
			default: dh = $urandom_range(1, 256);
		endcase
		case ($urandom_range(0, 9))
			0: sw = 1;
			1: sw = $urandom_range(1, 4096);
			default: sw = $urandom_range(1, 64);
		endcase
		case ($urandom_range(0, 9))
			0: sh = 1;
			1: sh = $urandom_range(1, 4096);
			default: sh = $urandom_range(1, 64);
		endcase
		cx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, sw - 1);
		cy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, sh - 1);
		case ($urandom_range(0, 7))
			0: key = 24'hFF_FFFF;
			1: key = 24'h00_0000;
			default: key = 24'($urandom);
		endcase
		return make_cfg(key, dw, dh, sw, sh, cx, cy, 2'($urandom_range(0, 3)));
	endfunction

	// Mostly pixels of the current sprite placed near the destination; some raw noise.
	function automatic ckb_pkg::pix_in_t random_pixel(input bit noise);
		ckb_pkg::pix_in_t p;
		int sw, sh, dw, dh;
		p.src_pixel   = $urandom;
		p.dest_pixel  = $urandom;
		p.tint_player = 1'($urandom_range(0, 1));
		if (noise) begin
			p.draw_x       = 16'($urandom);
			p.draw_y       = 16'($urandom);
			p.src_col      = 12'($urandom);
			p.src_row      = 12'($urandom);
			p.draw_percent = 7'($urandom);
			return p;
		end
		sw = int'(blit_regs.sprite_width);
		sh = int'(blit_regs.sprite_height);
		dw = int'(blit_regs.dest_width);
		dh = int'(blit_regs.dest_height);
		p.src_col = 12'($urandom_range(0, sw - 1));
		p.src_row = 12'($urandom_range(0, sh - 1));
		p.draw_x = 16'(int'(blit_regs.center_x) + int'($urandom_range(0, dw + sw)) - sw);
		p.draw_y = 16'(int'(blit_regs.center_y) + int'($urandom_range(0, dh + sh)) - sh);
		case ($urandom_range(0, 7))
			0, 1, 2, 3: p.draw_percent = 7'd100;
			4: p.draw_percent = 7'($urandom_range(101, 127));
			default: p.draw_percent = 7'($urandom_range(0, 100));
		endcase
		if ($urandom_range(0, 7) == 0)
			p.src_pixel[23:0] = blit_regs.color_key;
		return p;
	endfunction

	task automatic send_pixel(input ckb_pkg::pix_in_t p);
		if (!steady && $urandom_range(0, 3) == 0) begin
			pix_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pix_in.draw_x       <= p.draw_x;
		pix_in.draw_y       <= p.draw_y;
		pix_in.src_col      <= p.src_col;
		pix_in.src_row      <= p.src_row;
		pix_in.src_pixel    <= p.src_pixel;
		pix_in.dest_pixel   <= p.dest_pixel;
		pix_in.tint_player  <= p.tint_player;
		pix_in.draw_percent <= p.draw_percent;
		pix_in.valid        <= 1'b1;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		pending_writes.push_back(predict_blit(p));
	endtask

	task automatic send_random_pixels(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(random_pixel($urandom_range(0, 9) == 0));
	endtask

	// Hold the input idle until every result is back, then let the pipe settle.
	task automatic drain_pixels();
		pix_in.valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ckb_pkg::CfgIndexBits-1:0] idx,
			input logic [23:0] data);
		cfg.index <= idx;
		cfg.data  <= data;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (idx)
			ckb_pkg::REG_COLOR_KEY:     blit_regs.color_key = data;
			ckb_pkg::REG_DEST_WIDTH:    blit_regs.dest_width = data[12:0];
			ckb_pkg::REG_DEST_HEIGHT:   blit_regs.dest_height = data[12:0];
			ckb_pkg::REG_SPRITE_WIDTH:  blit_regs.sprite_width = data[12:0];
			ckb_pkg::REG_SPRITE_HEIGHT: blit_regs.sprite_height = data[12:0];
			ckb_pkg::REG_CENTER_X:      blit_regs.center_x = data[11:0];
			ckb_pkg::REG_CENTER_Y:      blit_regs.center_y = data[11:0];
			ckb_pkg::REG_SPRITE_MODE:   blit_regs.sprite_mode = data[1:0];
		endcase
	endtask

	task automatic program_regs(input ckb_pkg::cfg_t c);
		drain_pixels();
		write_reg(ckb_pkg::REG_COLOR_KEY, c.color_key);
		write_reg(ckb_pkg::REG_DEST_WIDTH, 24'(c.dest_width));
		write_reg(ckb_pkg::REG_DEST_HEIGHT, 24'(c.dest_height));
		write_reg(ckb_pkg::REG_SPRITE_WIDTH, 24'(c.sprite_width));
		write_reg(ckb_pkg::REG_SPRITE_HEIGHT, 24'(c.sprite_height));
		write_reg(ckb_pkg::REG_CENTER_X, 24'(c.center_x));
		write_reg(ckb_pkg::REG_CENTER_Y, 24'(c.center_y));
		write_reg(ckb_pkg::REG_SPRITE_MODE, 24'(c.sprite_mode));
		cfg.valid <= 1'b0;
	endtask

	// Register values straight out of reset: 640x480, 1x1 sprite, white key.
	task automatic test_reset_values();
		send_pixel(make_pixel(0, 0, 0, 0, 32'hA012_3456, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(639, 479, 0, 0, 32'h0034_5678, 32'h0, 1'b1, 100));
		send_pixel(make_pixel(640, 0, 0, 0, 32'h0034_5678, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(-1, 0, 0, 0, 32'h0034_5678, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(5, 5, 0, 0, 32'h7FFF_FFFF, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(5, 5, 0, 0, 32'h00AB_CDEF, 32'h0, 1'b0, 0));
	endtask

	task automatic test_clipping();
		program_regs(make_cfg(24'h00_0000, 40, 20, 16, 8, 8, 4, ckb_pkg::MODE_CHAR));
		// left edge: five columns clipped, visible width eleven
		send_pixel(make_pixel(3, 10, 4, 2, 32'h1122_3344, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(3, 10, 10, 2, 32'h1122_3344, 32'h0, 1'b0, 50));
		send_pixel(make_pixel(3, 10, 11, 2, 32'h1122_3344, 32'h0, 1'b0, 50));
		// right edge: six columns clipped
		send_pixel(make_pixel(38, 10, 9, 2, 32'h5566_7788, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(38, 10, 10, 2, 32'h5566_7788, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(20, 10, 16, 2, 32'h5566_7788, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(20, 10, 3, 8, 32'h5566_7788, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(20, 2, 3, 1, 32'h99AA_BBCC, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(20, 22, 3, 4, 32'h99AA_BBCC, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(20, 10, 15, 3, 32'h99AA_BBCC, 32'h0, 1'b0, 127));
		// sprite wider and taller than the destination: both sides clip at once
		program_regs(make_cfg(24'h12_3456, 10, 4, 24, 12, 12, 6, ckb_pkg::MODE_CHAR));
		send_pixel(make_pixel(7, 5, 5, 1, 32'hDDEE_FF01, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(7, 5, 14, 4, 32'hDDEE_FF01, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(7, 5, 15, 1, 32'hDDEE_FF01, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(7, 5, 10, 1, 32'hDDEE_FF01, 32'h0, 1'b0, 50));
	endtask

	task automatic test_shading();
		program_regs(make_cfg(24'hFF_00FF, 4096, 4096, 4096, 4096, 0, 0,
			ckb_pkg::MODE_SHADOW));
		send_pixel(make_pixel(0, 0, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFE_FDFC, 1'b1, 100));
		send_pixel(make_pixel(0, 0, 1, 1, 32'h0010_2030, 32'h0080_8080, 1'b0, 100));
		program_regs(make_cfg(24'hFF_00FF, 640, 480, 4, 4, 0, 0, ckb_pkg::MODE_GAUGE));
		send_pixel(make_pixel(9, 9, 2, 2, 32'h00F0_E0D0, 32'h0, 1'b1, 100));
		program_regs(make_cfg(24'hFF_00FF, 640, 480, 4, 4, 0, 0, MODE_UNUSED));
		send_pixel(make_pixel(9, 9, 2, 2, 32'h00F0_E0D1, 32'h0, 1'b1, 100));
	endtask

	task automatic test_size_limits();
		program_regs(make_cfg(24'h00_0000, 0, 480, 8, 8, 0, 0, ckb_pkg::MODE_CHAR));
		send_pixel(make_pixel(0, 0, 1, 1, 32'h0012_3456, 32'h0, 1'b0, 100));
		program_regs(make_cfg(24'h00_0000, 640, 480, 8, 0, 0, 0, ckb_pkg::MODE_CHAR));
		send_pixel(make_pixel(0, 0, 1, 0, 32'h0012_3456, 32'h0, 1'b0, 100));
		// sizes beyond the coordinate range: the coordinate limit decides
		program_regs(make_cfg(24'h00_0000, 8191, 8191, 8191, 8191, 4095, 4095,
			ckb_pkg::MODE_SHADOW));
		send_pixel(make_pixel(8191, 4095, 0, 0, 32'h0012_3456, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(-32768, 32767, 4095, 4095, 32'h0012_3456, 32'h0, 1'b0, 100));
		send_pixel(make_pixel(4095, 4095, 4095, 4095, 32'h0012_3456, 32'h0042_4242, 1'b0, 100));
	endtask

	task automatic test_random_blits();
		program_regs(make_cfg(24'h00_0000, 1, 1, 1, 1, 0, 0, ckb_pkg::MODE_CHAR));
		send_random_pixels(130);
		program_regs(make_cfg(24'hFF_FFFF, 4096, 4096, 4096, 4096, 4095, 4095,
			ckb_pkg::MODE_SHADOW));
		send_random_pixels(130);
		for (int phase = 0; phase < 10; phase++) begin
			steady = (phase % 3 == 2);
			program_regs(random_cfg());
			send_random_pixels(130);
		end
		steady = 1'b0;
	endtask

	task automatic test_streaming();
		steady = 1'b1;
		program_regs(random_cfg());
		send_random_pixels(220);
	endtask

	// Check each result transaction and stall the output in random bursts.
	always @(posedge clk) begin
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (pending_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit)
					$display("unexpected result: we=%0b col=%0d row=%0d rgb=%06h",
						pix_out.write_enable, pix_out.dest_col, pix_out.dest_row,
						pix_out.out_pixel);
			end else begin
				want = pending_writes.pop_front();
				if (want.we !== pix_out.write_enable || want.col !== pix_out.dest_col ||
						want.row !== pix_out.dest_row || want.rgb !== pix_out.out_pixel) begin
					mismatches++;
					if (mismatches <= ReportLimit) begin
						$write("mismatch: expected we=%0b col=%0d row=%0d rgb=%06h,",
							want.we, want.col, want.row, want.rgb);
						$display(" got we=%0b col=%0d row=%0d rgb=%06h",
							pix_out.write_enable, pix_out.dest_col, pix_out.dest_row,
							pix_out.out_pixel);
					end
				end
			end
		end
		if (stall_left != 0) begin
			stall_left--;
			pix_out.ready <= 1'b0;
		end else if (!steady && $urandom_range(0, 7) == 0) begin
			stall_left = int'($urandom_range(0, 5));
			pix_out.ready <= 1'b0;
		end else begin
			pix_out.ready <= 1'b1;
		end
	end

	initial begin
		arst_n = 1'b0;
		pix_in.valid = 1'b0;
		pix_in.draw_x = '0;
		pix_in.draw_y = '0;
		pix_in.src_col = '0;
		pix_in.src_row = '0;
		pix_in.src_pixel = '0;
		pix_in.dest_pixel = '0;
		pix_in.tint_player = 1'b0;
		pix_in.draw_percent = '0;
		pix_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = ckb_pkg::REG_COLOR_KEY;
		cfg.data = '0;
		blit_regs = make_cfg(ckb_pkg::RESET_COLOR_KEY, int'(ckb_pkg::RESET_DEST_WIDTH),
			int'(ckb_pkg::RESET_DEST_HEIGHT), int'(ckb_pkg::RESET_SPRITE_DIM),
			int'(ckb_pkg::RESET_SPRITE_DIM), 0, 0, ckb_pkg::MODE_CHAR);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_clipping();
		test_shading();
		test_size_limits();
		test_random_blits();
		test_streaming();
		drain_pixels();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
